@@ rtl/core/usfd_pkg.sv @@
// Shared types and constants for the UART status frame deframer.
package usfd_pkg;

  localparam int STATUS_BYTES = 15;
  localparam int HDR_LEN      = 6;
  localparam int CSUM_POS     = 5;
  localparam int LEN_LO_POS   = 3;
  localparam int LEN_HI_POS   = 4;
  localparam int CMD_LO_POS   = 7;
  localparam int CMD_HI_POS   = 8;
  localparam int BODY_MIN     = 4;
  localparam int PAYLOAD_POS  = 10;

  localparam int CNT_W   = 17;
  localparam int IDX_W   = $clog2(STATUS_BYTES);
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;

  localparam logic [7:0]  HEADER_RST  = 8'd165;
  localparam logic [15:0] MAX_LEN_RST = 16'd1024;
  localparam logic [15:0] STAT_CMD_RST = 16'd0;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_HEADER   = 2'd0,
    CFG_MAX_LEN  = 2'd1,
    CFG_STAT_CMD = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RC_STATUS      = 3'd0,
    RC_OTHER_CMD   = 3'd1,
    RC_BAD_CSUM    = 3'd2,
    RC_SHORT_BODY  = 3'd3,
    RC_SHORT_STAT  = 3'd4,
    RC_OVERLONG    = 3'd5
  } rc_t;

  // Role of one byte within a frame, set by the front end.
  typedef enum logic [8:0] {
    K_HDR    = 9'b000000001,
    K_SUM    = 9'b000000010,
    K_CSUM   = 9'b000000100,
    K_LEN_LO = 9'b000001000,
    K_LEN_HI = 9'b000010000,
    K_CMD_LO = 9'b000100000,
    K_CMD_HI = 9'b001000000,
    K_STAT   = 9'b010000000,
    K_OVER   = 9'b100000000
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } tok_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [15:0] command_code;
    logic [15:0] payload_length;
    logic [23:0] firmware_version;
    logic [2:0]  flag_bits;
    logic [7:0]  container_state;
    logic [7:0]  fog_status;
    logic [7:0]  target_humidity;
    logic [7:0]  current_humidity;
    logic [7:0]  current_temperature;
    logic [23:0] level_bits;
    logic [7:0]  exception_code;
  } res_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] max_body_length;
    logic [15:0] status_command;
  } cfg_t;

endpackage

@@ rtl/core/usfd_if.sv @@
// Channel interfaces: received bytes, results and register writes.
interface usfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface usfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic [15:0] command_code;
  logic [15:0] payload_length;
  logic [23:0] firmware_version;
  logic [2:0]  flag_bits;
  logic [7:0]  container_state;
  logic [7:0]  fog_status;
  logic [7:0]  target_humidity;
  logic [7:0]  current_humidity;
  logic [7:0]  current_temperature;
  logic [23:0] level_bits;
  logic [7:0]  exception_code;
  modport source (
    output valid, input ready,
    output result_code, command_code, payload_length, firmware_version, flag_bits,
    output container_state, fog_status, target_humidity, current_humidity,
    output current_temperature, level_bits, exception_code
  );
  modport sink (
    input valid, output ready,
    input result_code, command_code, payload_length, firmware_version, flag_bits,
    input container_state, fog_status, target_humidity, current_humidity,
    input current_temperature, level_bits, exception_code
  );
endinterface

interface usfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/core/usfd_front.sv @@
// Front end: frame tracking and per-byte classification into tokens.
module usfd_front (
  input  logic            clk,
  input  logic            rst_n,
  usfd_in_if.sink         in_chan,
  input  usfd_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output usfd_pkg::tok_t  q_tok
);
  import usfd_pkg::*;

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] stat_off;
  logic [15:0]      len;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign cnt_inc       = cnt_r + CNT_W'(1);
  assign stat_off      = cnt_r - CNT_W'(PAYLOAD_POS);
  assign len           = {in_chan.rx_byte, len_lo_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    exp_nxt      = exp_r;
    len_lo_nxt   = len_lo_r;
    q_push       = 1'b0;
    q_tok.kind   = K_SUM;
    q_tok.last   = 1'b0;
    q_tok.idx    = stat_off[IDX_W-1:0];
    q_tok.data   = in_chan.rx_byte;
    if (accept) begin
      if (!in_frame_r) begin
        // hunt: only the header byte opens a frame
        if (in_chan.rx_byte == cfg.header_byte) begin
          q_push       = 1'b1;
          q_tok.kind   = K_HDR;
          in_frame_nxt = 1'b1;
          cnt_nxt      = CNT_W'(1);
          exp_nxt      = '0;
        end
      end else begin
        q_push  = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_r == CNT_W'(CSUM_POS)) begin
          q_tok.kind = K_CSUM;
        end else if (cnt_r == CNT_W'(LEN_LO_POS)) begin
          q_tok.kind = K_LEN_LO;
          len_lo_nxt = in_chan.rx_byte;
        end else if (cnt_r == CNT_W'(LEN_HI_POS)) begin
          q_tok.kind = K_LEN_HI;
          exp_nxt    = CNT_W'(len) + CNT_W'(HDR_LEN);
          if (len > cfg.max_body_length) begin
            q_tok.kind = K_OVER;
          end
        end else if (cnt_r == CNT_W'(CMD_LO_POS)) begin
          q_tok.kind = K_CMD_LO;
        end else if (cnt_r == CNT_W'(CMD_HI_POS)) begin
          q_tok.kind = K_CMD_HI;
        end else if (cnt_r >= CNT_W'(PAYLOAD_POS) &&
                     cnt_r < CNT_W'(PAYLOAD_POS + STATUS_BYTES)) begin
          q_tok.kind = K_STAT;
        end
        q_tok.last = (exp_r != '0) && (cnt_inc >= exp_r);
        // drop back to hunting on frame end or overlong length
        if (q_tok.last || q_tok.kind == K_OVER) begin
          in_frame_nxt = 1'b0;
          cnt_nxt      = '0;
          exp_nxt      = '0;
          len_lo_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      exp_r      <= '0;
      len_lo_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      exp_r      <= exp_nxt;
      len_lo_r   <= len_lo_nxt;
    end
  end

endmodule

@@ rtl/core/usfd_fifo.sv @@
// Token queue between the front end and the back end.
module usfd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  usfd_pkg::tok_t push_tok,
  input  logic           pop,
  output usfd_pkg::tok_t head_tok,
  output logic           full,
  output logic           empty
);
  import usfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  tok_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W_Q'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W_Q'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/usfd_back.sv @@
// Back end: checksum, command and status capture, result decode and output register.
module usfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  usfd_pkg::cfg_t  cfg,
  input  usfd_pkg::tok_t  head_tok,
  input  logic            q_empty,
  output logic            q_pop,
  usfd_out_if.source      out_chan
);
  import usfd_pkg::*;

  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  stat_r [STATUS_BYTES];
  logic [7:0]  sv [STATUS_BYTES];
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;
  logic        produces;
  logic        slot_free;
  logic [15:0] plen;

  assign produces  = head_tok.last || (head_tok.kind == K_OVER);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign q_pop     = !q_empty && (!produces || slot_free);
  assign plen      = len_nxt - 16'(BODY_MIN);

  always_comb begin
    sum_nxt  = sum_r;
    csum_nxt = csum_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    if (q_pop) begin
      unique case (head_tok.kind)
        K_HDR: begin
          sum_nxt  = head_tok.data;
          csum_nxt = '0;
          cmd_nxt  = '0;
        end
        K_CSUM:   csum_nxt = head_tok.data;
        K_LEN_LO: begin
          sum_nxt      = sum_r + head_tok.data;
          len_nxt[7:0] = head_tok.data;
        end
        K_LEN_HI: begin
          sum_nxt       = sum_r + head_tok.data;
          len_nxt[15:8] = head_tok.data;
        end
        K_CMD_LO: begin
          sum_nxt      = sum_r + head_tok.data;
          cmd_nxt[7:0] = head_tok.data;
        end
        K_CMD_HI: begin
          sum_nxt       = sum_r + head_tok.data;
          cmd_nxt[15:8] = head_tok.data;
        end
        default: sum_nxt = sum_r + head_tok.data;
      endcase
    end
  end

  // status view including the byte landing this cycle
  always_comb begin
    for (int i = 0; i < STATUS_BYTES; i++) begin
      sv[i] = (q_pop && head_tok.kind == K_STAT && head_tok.idx == IDX_W'(i)) ?
              head_tok.data : stat_r[i];
    end
  end

  always_comb begin
    res_nxt = '0;
    if (head_tok.kind == K_OVER) begin
      res_nxt.result_code = RC_OVERLONG;
    end else if (~sum_nxt != csum_nxt) begin
      res_nxt.result_code = RC_BAD_CSUM;
    end else if (len_nxt < 16'(BODY_MIN)) begin
      res_nxt.result_code = RC_SHORT_BODY;
    end else begin
      res_nxt.command_code   = cmd_nxt;
      res_nxt.payload_length = plen;
      if (cmd_nxt != cfg.status_command) begin
        res_nxt.result_code = RC_OTHER_CMD;
      end else if (plen < 16'(STATUS_BYTES)) begin
        res_nxt.result_code = RC_SHORT_STAT;
      end else begin
        res_nxt.result_code         = RC_STATUS;
        res_nxt.firmware_version    = {sv[0], sv[1], sv[2]};
        res_nxt.flag_bits           = {sv[6] != 8'd0, sv[5] != 8'd0, sv[3] != 8'd0};
        res_nxt.container_state     = sv[4];
        res_nxt.fog_status          = sv[7];
        res_nxt.target_humidity     = sv[8];
        res_nxt.current_humidity    = sv[9];
        res_nxt.current_temperature = sv[10];
        res_nxt.level_bits          = {sv[11], sv[12], sv[13]};
        res_nxt.exception_code      = sv[14];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && produces) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head_tok.kind == K_STAT) begin
      stat_r[head_tok.idx] <= head_tok.data;
    end
    if (q_pop && produces) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      csum_r      <= '0;
      cmd_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      csum_r      <= csum_nxt;
      cmd_r       <= cmd_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.result_code         = res_r.result_code;
  assign out_chan.command_code        = res_r.command_code;
  assign out_chan.payload_length      = res_r.payload_length;
  assign out_chan.firmware_version    = res_r.firmware_version;
  assign out_chan.flag_bits           = res_r.flag_bits;
  assign out_chan.container_state     = res_r.container_state;
  assign out_chan.fog_status          = res_r.fog_status;
  assign out_chan.target_humidity     = res_r.target_humidity;
  assign out_chan.current_humidity    = res_r.current_humidity;
  assign out_chan.current_temperature = res_r.current_temperature;
  assign out_chan.level_bits          = res_r.level_bits;
  assign out_chan.exception_code      = res_r.exception_code;

endmodule

@@ rtl/core/uart_status_frame_deframer_unit.sv @@
// UART status frame deframer: top level with configuration registers.
// Usage:
//   in_chan carries one received byte per beat (rx_byte). Bytes are dropped until
//   the header byte is seen; the frame is then tracked by position, with the body
//   length from bytes 3 and 4 and the checksum in byte 5.
//   out_chan carries at most one result beat per frame: code, command, payload
//   length and, for a complete status frame, the decoded status fields.
//   cfg_chan writes header_byte (index 0), max_body_length (1) and status_command
//   (2); other indexes are ignored. cfg_chan.ready is always high. Write only while
//   the block is idle.
// Throughput: one byte per cycle while the token queue is not full. The final byte's
//   token is first written into the token queue and then decoded into the output
//   register when it is popped; out_chan.valid comes from that register.
// Stall: a stalled receiver holds the result register; non-final bytes keep
//   draining, and the FIFO_DEPTH-entry token queue fills only when a second
//   result waits behind the held one, at which point in_chan.ready drops.
// Reset: synchronous, active low; the block returns to hunting for a header,
//   the queue empties and the configuration registers and out_chan.valid take their reset values.
module uart_status_frame_deframer_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  usfd_in_if.sink    in_chan,
  usfd_out_if.source out_chan,
  usfd_cfg_if.sink   cfg_chan
);
  import usfd_pkg::*;

  cfg_t cfg_r;
  tok_t push_tok;
  tok_t head_tok;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte     <= HEADER_RST;
      cfg_r.max_body_length <= MAX_LEN_RST;
      cfg_r.status_command  <= STAT_CMD_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        CFG_HEADER:   cfg_r.header_byte     <= cfg_chan.wdata[7:0];
        CFG_MAX_LEN:  cfg_r.max_body_length <= cfg_chan.wdata;
        CFG_STAT_CMD: cfg_r.status_command  <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  usfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_tok   (push_tok)
  );

  usfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .pop      (q_pop),
    .head_tok (head_tok),
    .full     (q_full),
    .empty    (q_empty)
  );

  usfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_tok (head_tok),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
